// File: src/crec_pkg.sv
// Shared types and helper logic for the circle/rectangle edge crossing block.
// No dependencies; imported by circle_rect_edge_crossing.
package crec_pkg;

  // Edge index into the per-edge arrays.
  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_BOTTOM = 2'd1,
    EDGE_LEFT   = 2'd2,
    EDGE_RIGHT  = 2'd3
  } edge_idx_t;

  localparam int unsigned NUM_EDGES = 4;

  // Sign of a coordinate difference, kept beside its magnitude.
  typedef struct packed {
    logic pos;
    logic neg;
  } diff_sign_t;

  // Final crossing decision for one edge. "lo" is the difference from the
  // center to the low end of the span, "hi" the difference to the high end.
  // The gt/lt inputs compare the discriminant against the squared distances.
  function automatic logic edge_crossing(
    input logic       disc_ok,
    input diff_sign_t lo_sign,
    input diff_sign_t hi_sign,
    input logic       gt_lo,
    input logic       lt_lo,
    input logic       gt_hi,
    input logic       lt_hi
  );
    logic near_pt;
    logic far_pt;
    begin
      // Crossing point center - sqrt(disc) lies strictly inside the span.
      near_pt = (hi_sign.pos || gt_hi) && lo_sign.neg && lt_lo;
      // Crossing point center + sqrt(disc) lies strictly inside the span.
      far_pt  = (lo_sign.neg || gt_lo) && hi_sign.pos && lt_hi;
      return disc_ok && (near_pt || far_pt);
    end
  endfunction

endpackage

// File: src/circle_rect_edge_crossing.sv
// Top level: four-stage pipeline that tests whether a circle outline crosses
// a rectangle edge strictly inside its span. Depends on crec_pkg.
//
//   Channel | Ports                                   | Direction
//   --------+-----------------------------------------+----------
//   in      | in_valid/in_ready, in_radius..bottom_y  | input
//   out     | out_valid/out_ready, out_hit            | output
//
// One transaction per cycle is accepted while no result waits untaken at the
// output; each result passes through the stage chain in order: differences,
// squares, discriminants, compares.
// rst_n (synchronous, active low) clears only the stage valid bits.
// When the output holds a result that is not taken, every stage holds and
// in_ready drops; nothing is lost or repeated.
module circle_rect_edge_crossing #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [COORD_BITS-2:0]        in_radius,
  input  logic signed [COORD_BITS-1:0] in_center_x,
  input  logic signed [COORD_BITS-1:0] in_center_y,
  input  logic signed [COORD_BITS-1:0] in_left_x,
  input  logic signed [COORD_BITS-1:0] in_top_y,
  input  logic signed [COORD_BITS-1:0] in_right_x,
  input  logic signed [COORD_BITS-1:0] in_bottom_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit
);
  import crec_pkg::*;

  localparam int unsigned DIFF_W = COORD_BITS + 1;       // signed difference
  localparam int unsigned PROD_W = 2 * DIFF_W;           // raw product width
  localparam int unsigned SQ_W   = 2 * COORD_BITS + 1;   // holds (2^N)^2
  localparam int unsigned RSQ_W  = 2 * (COORD_BITS - 1); // radius squared

  // Pipeline advance: all stages move together unless the result is stuck.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt;

  // Stage 1: edge line minus center, as magnitude and sign.
  logic [DIFF_W-1:0]     mag1_r  [NUM_EDGES];
  logic [DIFF_W-1:0]     mag1_nxt[NUM_EDGES];
  diff_sign_t            sgn1_r  [NUM_EDGES];
  diff_sign_t            sgn1_nxt[NUM_EDGES];
  logic [COORD_BITS-2:0] rad1_r;

  // Stage 2: squares.
  logic [SQ_W-1:0]       sq2_r   [NUM_EDGES];
  logic [SQ_W-1:0]       sq2_nxt [NUM_EDGES];
  diff_sign_t            sgn2_r  [NUM_EDGES];
  logic [RSQ_W-1:0]      rsq2_r;
  logic [RSQ_W-1:0]      rsq2_nxt;

  // Stage 3: discriminants.
  logic [SQ_W-1:0]       disc3_r [NUM_EDGES];
  logic [SQ_W-1:0]       disc3_nxt[NUM_EDGES];
  logic [NUM_EDGES-1:0]  ok3_r;
  logic [NUM_EDGES-1:0]  ok3_nxt;
  logic [SQ_W-1:0]       sq3_r   [NUM_EDGES];
  diff_sign_t            sgn3_r  [NUM_EDGES];

  // Stage 4: result register.
  logic hit4_r;
  logic hit4_nxt;

  // Stage 1 logic: differences of each edge line against the matching center.
  logic signed [DIFF_W-1:0] line_w  [NUM_EDGES];
  logic signed [DIFF_W-1:0] cent_w  [NUM_EDGES];
  logic signed [DIFF_W-1:0] diff_w  [NUM_EDGES];

  always_comb begin
    line_w[EDGE_TOP]    = DIFF_W'(in_top_y);
    line_w[EDGE_BOTTOM] = DIFF_W'(in_bottom_y);
    line_w[EDGE_LEFT]   = DIFF_W'(in_left_x);
    line_w[EDGE_RIGHT]  = DIFF_W'(in_right_x);
    cent_w[EDGE_TOP]    = DIFF_W'(in_center_y);
    cent_w[EDGE_BOTTOM] = DIFF_W'(in_center_y);
    cent_w[EDGE_LEFT]   = DIFF_W'(in_center_x);
    cent_w[EDGE_RIGHT]  = DIFF_W'(in_center_x);
    for (int i = 0; i < NUM_EDGES; i++) begin
      diff_w[i]       = line_w[i] - cent_w[i];
      sgn1_nxt[i].neg = diff_w[i][DIFF_W-1];
      sgn1_nxt[i].pos = !diff_w[i][DIFF_W-1] && (diff_w[i] != '0);
      mag1_nxt[i]     = diff_w[i][DIFF_W-1] ? DIFF_W'(-diff_w[i]) : DIFF_W'(diff_w[i]);
    end
  end

  // Stage 2 logic: one square per edge difference plus the radius square.
  logic [PROD_W-1:0] prod_w[NUM_EDGES];

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      prod_w[i]  = PROD_W'(mag1_r[i]) * PROD_W'(mag1_r[i]);
      sq2_nxt[i] = prod_w[i][SQ_W-1:0];
    end
    rsq2_nxt = RSQ_W'(rad1_r) * RSQ_W'(rad1_r);
  end

  // Stage 3 logic: disc = r^2 - d^2 for each edge line.
  logic [SQ_W:0] dfull_w[NUM_EDGES];

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      dfull_w[i]   = (SQ_W+1)'(rsq2_r) - (SQ_W+1)'(sq2_r[i]);
      ok3_nxt[i]   = !dfull_w[i][SQ_W];
      disc3_nxt[i] = dfull_w[i][SQ_W-1:0];
    end
  end

  // Stage 4 logic: bound compares and the OR over all edges.
  // Horizontal edges span from left to right, vertical ones from top to bottom.
  logic [NUM_EDGES-1:0] edge_hit_w;

  always_comb begin
    edge_hit_w[EDGE_TOP] = edge_crossing(ok3_r[EDGE_TOP],
      sgn3_r[EDGE_LEFT], sgn3_r[EDGE_RIGHT],
      disc3_r[EDGE_TOP] > sq3_r[EDGE_LEFT],  disc3_r[EDGE_TOP] < sq3_r[EDGE_LEFT],
      disc3_r[EDGE_TOP] > sq3_r[EDGE_RIGHT], disc3_r[EDGE_TOP] < sq3_r[EDGE_RIGHT]);
    edge_hit_w[EDGE_BOTTOM] = edge_crossing(ok3_r[EDGE_BOTTOM],
      sgn3_r[EDGE_LEFT], sgn3_r[EDGE_RIGHT],
      disc3_r[EDGE_BOTTOM] > sq3_r[EDGE_LEFT],  disc3_r[EDGE_BOTTOM] < sq3_r[EDGE_LEFT],
      disc3_r[EDGE_BOTTOM] > sq3_r[EDGE_RIGHT], disc3_r[EDGE_BOTTOM] < sq3_r[EDGE_RIGHT]);
    edge_hit_w[EDGE_LEFT] = edge_crossing(ok3_r[EDGE_LEFT],
      sgn3_r[EDGE_TOP], sgn3_r[EDGE_BOTTOM],
      disc3_r[EDGE_LEFT] > sq3_r[EDGE_TOP],    disc3_r[EDGE_LEFT] < sq3_r[EDGE_TOP],
      disc3_r[EDGE_LEFT] > sq3_r[EDGE_BOTTOM], disc3_r[EDGE_LEFT] < sq3_r[EDGE_BOTTOM]);
    edge_hit_w[EDGE_RIGHT] = edge_crossing(ok3_r[EDGE_RIGHT],
      sgn3_r[EDGE_TOP], sgn3_r[EDGE_BOTTOM],
      disc3_r[EDGE_RIGHT] > sq3_r[EDGE_TOP],    disc3_r[EDGE_RIGHT] < sq3_r[EDGE_TOP],
      disc3_r[EDGE_RIGHT] > sq3_r[EDGE_BOTTOM], disc3_r[EDGE_RIGHT] < sq3_r[EDGE_BOTTOM]);
    hit4_nxt = |edge_hit_w;
  end

  // Valid bits shift along with the data.
  always_comb begin
    v1_nxt = in_valid;
    v2_nxt = v1_r;
    v3_nxt = v2_r;
    v4_nxt = v3_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Payload registers, held on a stall.
  always_ff @(posedge clk) begin
    if (adv) begin
      rad1_r <= in_radius;
      rsq2_r <= rsq2_nxt;
      ok3_r  <= ok3_nxt;
      hit4_r <= hit4_nxt;
      for (int i = 0; i < NUM_EDGES; i++) begin
        mag1_r[i]  <= mag1_nxt[i];
        sgn1_r[i]  <= sgn1_nxt[i];
        sq2_r[i]   <= sq2_nxt[i];
        sgn2_r[i]  <= sgn1_r[i];
        disc3_r[i] <= disc3_nxt[i];
        sq3_r[i]   <= sq2_r[i];
        sgn3_r[i]  <= sgn2_r[i];
      end
    end
  end

  assign out_valid = v4_r;
  assign out_hit   = hit4_r;

endmodule

// File: tb/tb_circle_rect_edge_crossing.sv
`timescale 1ns / 1ps
// Self-checking testbench for circle_rect_edge_crossing: a scoreboard class predicts the
// hit flag of every accepted transaction; plain tasks drive the input channel.
// Depends only on the RTL of the block.
module tb_circle_rect_edge_crossing;

  localparam int unsigned COORD_W     = 16;
  localparam int          LIMIT_CYCLES = 50000;
  localparam int          RANDOM_PAIRS = 900;

  // One circle/rectangle pair as carried by an input transaction.
  typedef struct packed {
    logic [COORD_W-2:0]        radius;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] bottom_y;
  } shape_pair_t;

  // Keeps the expected hit flags in order and compares arriving results against them.
  class hit_scoreboard;
    bit expected_hits[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Does the outline cross one edge line strictly inside (lo, hi)? The crossing
    // points sit at c_along +/- sqrt(disc); every bound is compared squared.
    function bit edge_crossed(longint r, longint line, longint c_line, longint c_along,
                              longint lo, longint hi);
      longint d, disc, a, b;
      bit near_pt, far_pt;
      d = line - c_line;
      disc = r * r - d * d;
      if (disc < 0) return 1'b0;
      a = c_along - hi;
      b = c_along - lo;
      near_pt = (a < 0 || disc > a * a) && b > 0 && disc < b * b;
      a = lo - c_along;
      b = hi - c_along;
      far_pt = (a < 0 || disc > a * a) && b > 0 && disc < b * b;
      return near_pt || far_pt;
    endfunction

    function bit crossing_hit(shape_pair_t p);
      longint r, cx, cy, lx, ty, rx, by;
      r  = longint'(p.radius);
      cx = longint'(p.center_x);
      cy = longint'(p.center_y);
      lx = longint'(p.left_x);
      ty = longint'(p.top_y);
      rx = longint'(p.right_x);
      by = longint'(p.bottom_y);
      return edge_crossed(r, ty, cy, cx, lx, rx) || edge_crossed(r, by, cy, cx, lx, rx) ||
             edge_crossed(r, lx, cx, cy, ty, by) || edge_crossed(r, rx, cx, cy, ty, by);
    endfunction

    function void note_pair(shape_pair_t p);
      expected_hits.push_back(crossing_hit(p));
    endfunction

    function void check_hit(logic hit);
      bit want;
      if (expected_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%b", $time, hit);
        mismatches++;
      end else begin
        want = expected_hits.pop_front();
        if (hit !== want) begin
          $display("%0t: hit mismatch, expected %0b, actual %b", $time, want, hit);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [COORD_W-2:0]        in_radius;
  logic signed [COORD_W-1:0] in_center_x;
  logic signed [COORD_W-1:0] in_center_y;
  logic signed [COORD_W-1:0] in_left_x;
  logic signed [COORD_W-1:0] in_top_y;
  logic signed [COORD_W-1:0] in_right_x;
  logic signed [COORD_W-1:0] in_bottom_y;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_hit;

  hit_scoreboard sb = new();

  circle_rect_edge_crossing #(
    .COORD_BITS(COORD_W)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_radius  (in_radius),
    .in_center_x(in_center_x),
    .in_center_y(in_center_y),
    .in_left_x  (in_left_x),
    .in_top_y   (in_top_y),
    .in_right_x (in_right_x),
    .in_bottom_y(in_bottom_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_hit    (out_hit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic shape_pair_t make_pair(int r, int cx, int cy, int lx, int ty, int rx,
                                            int by);
    shape_pair_t p;
    p.radius   = r[COORD_W-2:0];
    p.center_x = cx[COORD_W-1:0];
    p.center_y = cy[COORD_W-1:0];
    p.left_x   = lx[COORD_W-1:0];
    p.top_y    = ty[COORD_W-1:0];
    p.right_x  = rx[COORD_W-1:0];
    p.bottom_y = by[COORD_W-1:0];
    return p;
  endfunction

  // A coordinate within +/- span of base, wrapping at the field width.
  function automatic logic signed [COORD_W-1:0] jitter(logic signed [COORD_W-1:0] base,
                                                       int span);
    int off;
    off = int'($urandom_range(0, 2 * span)) - span;
    return COORD_W'(int'(base) + off);
  endfunction

  function automatic logic signed [COORD_W-1:0] extreme_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      4: return 16'sh0001;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Mostly local scenes where the circle sits near the rectangle, so hits are common;
  // the rest are fully random fields, extreme values and exact tangents.
  function automatic shape_pair_t draw_shape_pair();
    shape_pair_t p;
    logic signed [COORD_W-1:0] tmp;
    int mode;
    mode = $urandom_range(0, 99);
    p.center_x = COORD_W'($urandom);
    p.center_y = COORD_W'($urandom);
    if (mode < 75 && mode >= 60) begin
      p.radius   = (COORD_W-1)'($urandom);
      p.left_x   = COORD_W'($urandom);
      p.top_y    = COORD_W'($urandom);
      p.right_x  = COORD_W'($urandom);
      p.bottom_y = COORD_W'($urandom);
    end else if (mode >= 75 && mode < 85) begin
      case ($urandom_range(0, 3))
        0: p.radius = '0;
        1: p.radius = '1;
        2: p.radius = (COORD_W-1)'(1);
        default: p.radius = (COORD_W-1)'($urandom);
      endcase
      p.center_x = extreme_coord();
      p.center_y = extreme_coord();
      p.left_x   = extreme_coord();
      p.top_y    = extreme_coord();
      p.right_x  = extreme_coord();
      p.bottom_y = extreme_coord();
    end else begin
      p.radius   = (COORD_W-1)'($urandom_range(0, 80));
      p.left_x   = jitter(p.center_x, 100);
      p.right_x  = jitter(p.center_x, 100);
      p.top_y    = jitter(p.center_y, 100);
      p.bottom_y = jitter(p.center_y, 100);
      // Put an edge line exactly at the circle's extent for the tangent case.
      if (mode >= 85) begin
        if ($urandom_range(0, 3) == 0) p.radius = '0;
        case ($urandom_range(0, 3))
          0: p.top_y    = COORD_W'(int'(p.center_y) - int'(p.radius));
          1: p.bottom_y = COORD_W'(int'(p.center_y) + int'(p.radius));
          2: p.left_x   = COORD_W'(int'(p.center_x) - int'(p.radius));
          default: p.right_x = COORD_W'(int'(p.center_x) + int'(p.radius));
        endcase
      end
      // Most rectangles are well formed; a few stay inverted.
      if ($urandom_range(0, 9) != 0) begin
        if (p.left_x > p.right_x) begin
          tmp = p.left_x;
          p.left_x = p.right_x;
          p.right_x = tmp;
        end
        if (p.top_y > p.bottom_y) begin
          tmp = p.top_y;
          p.top_y = p.bottom_y;
          p.bottom_y = tmp;
        end
      end
    end
    return p;
  endfunction

  // Offer one pair and hold it until the block takes the transaction.
  task automatic send_pair(shape_pair_t p);
    in_valid    <= 1'b1;
    in_radius   <= p.radius;
    in_center_x <= p.center_x;
    in_center_y <= p.center_y;
    in_left_x   <= p.left_x;
    in_top_y    <= p.top_y;
    in_right_x  <= p.right_x;
    in_bottom_y <= p.bottom_y;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(p);
  endtask

  task automatic pause_sender(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Result side: check every accepted transaction, then choose the next ready value.
  initial begin
    int rx_cycle;
    int hold_left;
    rx_cycle  = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_hit(out_hit);
      if (rst_n) rx_cycle++;
      // Two long hold-offs let the pipeline fill and stall its input.
      if (rx_cycle == 600 || rx_cycle == 900) hold_left = 60;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_cycle >= 150 && rx_cycle < 400) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 7);
      end
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("FAIL circle_rect_edge_crossing");
    $finish;
  end

  // Stimulus: reset, directed pairs, then random pairs with idle gaps and one drain pause.
  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_radius   <= '0;
    in_center_x <= '0;
    in_center_y <= '0;
    in_left_x   <= '0;
    in_top_y    <= '0;
    in_right_x  <= '0;
    in_bottom_y <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Degenerate and extreme fields.
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(make_pair(32767, -32768, -32768, -32768, -32768, 32767, 32767));
    send_pair(make_pair(32767, -1, -1, -1, -1, -1, -1));
    send_pair(make_pair(32767, 0, 0, -32768, -100, 32767, 100));
    send_pair(make_pair(32767, 32767, 32767, -32768, -32768, -32767, -32767));
    send_pair(make_pair('h5555, 'h5555, 'haaaa, 'h5555, 'haaaa, 'haaaa, 'h5555));
    send_pair(make_pair('h2aaa, 'haaaa, 'h5555, 'haaaa, 'h5555, 'h5555, 'haaaa));
    // Plain crossing, and containment both ways.
    send_pair(make_pair(10, 0, 0, 5, -20, 30, 20));
    send_pair(make_pair(5, 0, 0, -20, -20, 20, 20));
    send_pair(make_pair(100, 0, 0, -10, -10, 10, 10));
    // Zero radius on an edge line, inside and outside its span.
    send_pair(make_pair(0, 0, 0, -5, 0, 5, 10));
    send_pair(make_pair(0, 10, 0, -5, 0, 5, 10));
    send_pair(make_pair(0, 5, 3, 5, 0, 9, 10));
    // Tangent edges, inside the span and at a corner.
    send_pair(make_pair(10, 0, 0, -5, 10, 5, 30));
    send_pair(make_pair(10, 0, 0, 0, 10, 20, 30));
    send_pair(make_pair(10, 0, 0, -30, -5, -10, 5));
    // Inverted rectangles, and one of zero height.
    send_pair(make_pair(10, 0, 0, 30, -20, 5, 20));
    send_pair(make_pair(10, 0, 0, 5, 20, 30, -20));
    send_pair(make_pair(10, 0, 0, 30, 20, 5, -20));
    send_pair(make_pair(10, 0, 0, 5, 8, 30, 8));

    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      // Let every outstanding result drain once, mid run.
      if (i == 300) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
      end
      if (!(i >= 500 && i < 700) && $urandom_range(0, 99) < 7)
        pause_sender($urandom_range(1, 3));
      send_pair(draw_shape_pair());
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS circle_rect_edge_crossing");
    end else begin
      $display("FAIL circle_rect_edge_crossing");
    end
    $finish;
  end

endmodule
